@@ design/bpc_pkg.sv @@
// Shared types, constants and helper functions for the barometric compensation unit.
package bpc_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned RAW_W   = 24;
    localparam int unsigned PADDR_W = 5;

    localparam logic [31:0] B6_OFFSET   = 32'd4000;
    localparam logic [31:0] X3_OFFSET   = 32'd32768;
    localparam logic [31:0] B7_SCALE    = 32'd50000;
    localparam logic [31:0] P_COEF_SQ   = 32'd3038;
    localparam logic [31:0] P_COEF_LIN  = 32'd7357;
    localparam logic [31:0] P_COEF_OFS  = 32'd3791;
    localparam logic [1:0]  OSR_RESET   = 2'd1;

    typedef struct packed {
        logic              func;
        logic [RAW_W-1:0]  raw_value;
    } in_t;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] value;
        logic               div_by_zero;
    } out_t;

    typedef enum logic [2:0] {
        REG_OSR     = 3'd0,
        REG_AC1     = 3'd1,
        REG_AC2     = 3'd2,
        REG_AC3     = 3'd3,
        REG_AC4     = 3'd4,
        REG_AC5_AC6 = 3'd5,
        REG_MC_MD   = 3'd6,
        REG_B1_B2   = 3'd7
    } reg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T_MUL,
        S_T_X1,
        S_T_DEN,
        S_T_DIV,
        S_P_B6,
        S_P_SQM,
        S_P_SQ,
        S_P_X2,
        S_P_X1,
        S_P_B3,
        S_P_X3,
        S_P_B4M,
        S_P_B4,
        S_P_B7,
        S_P_DIV,
        S_P_SQP,
        S_P_K1,
        S_P_K2,
        S_P_SUM,
        S_DONE
    } state_t;

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

@@ design/baro_pressure_temp_compensation_unit.sv @@
// Top level: configuration registers, sequencer, shared multiplier and output register.
// An item with a zero divisor skips the divide and goes straight to the done state.
// The divider is shared by the temperature and pressure paths; one multiply runs per cycle.
// An item is accepted only in the idle state, entered the cycle after the previous result is
// loaded into the output register, so a new item is not taken before the last one is through.
// Reset clears the sequencer, output valid and stored b5, sets oversampling to 1 and the
// calibration registers to 0.
module baro_pressure_temp_compensation_unit
    import bpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_t                in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_t               out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Configuration registers
    logic [1:0]  osr_reg;
    logic [15:0] ac1_reg;
    logic [15:0] ac2_reg;
    logic [15:0] ac3_reg;
    logic [15:0] ac4_reg;
    logic [31:0] ac5_ac6_reg;
    logic [31:0] mc_md_reg;
    logic [31:0] b1_b2_reg;

    reg_idx_t cfg_idx;
    logic     cfg_wr;

    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            osr_reg     <= OSR_RESET;
            ac1_reg     <= '0;
            ac2_reg     <= '0;
            ac3_reg     <= '0;
            ac4_reg     <= '0;
            ac5_ac6_reg <= '0;
            mc_md_reg   <= '0;
            b1_b2_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_OSR:     osr_reg     <= pwdata[1:0];
                REG_AC1:     ac1_reg     <= pwdata[15:0];
                REG_AC2:     ac2_reg     <= pwdata[15:0];
                REG_AC3:     ac3_reg     <= pwdata[15:0];
                REG_AC4:     ac4_reg     <= pwdata[15:0];
                REG_AC5_AC6: ac5_ac6_reg <= pwdata;
                REG_MC_MD:   mc_md_reg   <= pwdata;
                REG_B1_B2:   b1_b2_reg   <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_OSR:     prdata = {30'd0, osr_reg};
            REG_AC1:     prdata = {16'd0, ac1_reg};
            REG_AC2:     prdata = {16'd0, ac2_reg};
            REG_AC3:     prdata = {16'd0, ac3_reg};
            REG_AC4:     prdata = {16'd0, ac4_reg};
            REG_AC5_AC6: prdata = ac5_ac6_reg;
            REG_MC_MD:   prdata = mc_md_reg;
            REG_B1_B2:   prdata = b1_b2_reg;
        endcase
    end

    // Decoded coefficients
    logic [31:0] ac1_s, ac2_s, ac3_s, ac4_u, ac5_u, ac6_u, mc_s, md_s, b1_s, b2_s;

    assign ac1_s = sx16(ac1_reg);
    assign ac2_s = sx16(ac2_reg);
    assign ac3_s = sx16(ac3_reg);
    assign ac4_u = {16'd0, ac4_reg};
    assign ac5_u = {16'd0, ac5_ac6_reg[31:16]};
    assign ac6_u = {16'd0, ac5_ac6_reg[15:0]};
    assign mc_s  = sx16(mc_md_reg[31:16]);
    assign md_s  = sx16(mc_md_reg[15:0]);
    assign b1_s  = sx16(b1_b2_reg[31:16]);
    assign b2_s  = sx16(b1_b2_reg[15:0]);

    // Sequencer and datapath registers
    state_t      state_reg, state_next;
    logic        func_reg;
    logic [23:0] raw_reg;
    logic [31:0] b5_reg, b5_next;
    logic [31:0] prod_reg;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] b6_reg, b6_next;
    logic [31:0] sq_reg, sq_next;
    logic [31:0] b3_reg, b3_next;
    logic [31:0] b4_reg, b4_next;
    logic [31:0] p_reg, p_next;
    logic [31:0] res_reg, res_next;
    logic        dz_reg, dz_next;
    logic        qfix_reg, qfix_next;
    out_t        out_reg;
    logic        out_valid_reg;

    logic [31:0] mul_a, mul_b;
    logic        div_start;
    logic [31:0] div_dividend, div_divisor;
    logic        div_done;
    logic [31:0] div_quotient;

    logic        in_acc;
    logic        out_load;
    logic [31:0] up_val;
    logic [31:0] den;
    logic [31:0] num_t;
    logic [31:0] q_signed;
    logic [31:0] b5_cand;
    logic [31:0] p_shift8;

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign up_val   = 32'(raw_reg) >> (4'd8 - {2'b00, osr_reg});
    assign den      = acc_reg + md_s;
    assign num_t    = {mc_s[20:0], 11'd0};
    assign q_signed = qfix_reg ? (32'd0 - div_quotient) : div_quotient;
    assign b5_cand  = acc_reg + q_signed;
    assign p_shift8 = asr32(p_reg, 5'd8);

    bpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_acc) state_next = in_data.func ? S_P_B6 : S_T_MUL;
            S_T_MUL:  state_next = S_T_X1;
            S_T_X1:   state_next = S_T_DEN;
            S_T_DEN:  state_next = (den == '0) ? S_DONE : S_T_DIV;
            S_T_DIV:  if (div_done) state_next = S_DONE;
            S_P_B6:   state_next = S_P_SQM;
            S_P_SQM:  state_next = S_P_SQ;
            S_P_SQ:   state_next = S_P_X2;
            S_P_X2:   state_next = S_P_X1;
            S_P_X1:   state_next = S_P_B3;
            S_P_B3:   state_next = S_P_X3;
            S_P_X3:   state_next = S_P_B4M;
            S_P_B4M:  state_next = S_P_B4;
            S_P_B4:   state_next = S_P_B7;
            S_P_B7:   state_next = (b4_reg == '0) ? S_DONE : S_P_DIV;
            S_P_DIV:  if (div_done) state_next = S_P_SQP;
            S_P_SQP:  state_next = S_P_K1;
            S_P_K1:   state_next = S_P_K2;
            S_P_K2:   state_next = S_P_SUM;
            S_P_SUM:  state_next = S_DONE;
            S_DONE:   if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control outputs: multiplier operands and divider start
    always_comb
    begin
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        unique case (state_reg)
            S_T_MUL:
            begin
                mul_a = {16'd0, raw_reg[15:0]} - ac6_u;
                mul_b = ac5_u;
            end
            S_T_DEN:
            begin
                div_start    = (den != '0);
                div_dividend = num_t[31] ? (32'd0 - num_t) : num_t;
                div_divisor  = den[31] ? (32'd0 - den) : den;
            end
            S_P_SQM:
            begin
                mul_a = b6_reg;
                mul_b = b6_reg;
            end
            S_P_SQ:
            begin
                mul_a = ac2_s;
                mul_b = b6_reg;
            end
            S_P_X2:
            begin
                mul_a = b2_s;
                mul_b = sq_reg;
            end
            S_P_X1:
            begin
                mul_a = ac3_s;
                mul_b = b6_reg;
            end
            S_P_B3:
            begin
                mul_a = b1_s;
                mul_b = sq_reg;
            end
            S_P_B4M:
            begin
                mul_a = ac4_u;
                mul_b = acc_reg + X3_OFFSET;
            end
            S_P_B4:
            begin
                mul_a = up_val - b3_reg;
                mul_b = B7_SCALE >> osr_reg;
            end
            S_P_B7:
            begin
                // Large b7 is divided first and doubled afterwards to stay in 32 bits.
                div_start    = (b4_reg != '0);
                div_dividend = prod_reg[31] ? prod_reg : {prod_reg[30:0], 1'b0};
                div_divisor  = b4_reg;
            end
            S_P_SQP:
            begin
                mul_a = p_shift8;
                mul_b = p_shift8;
            end
            S_P_K1:
            begin
                mul_a = prod_reg;
                mul_b = P_COEF_SQ;
            end
            S_P_K2:
            begin
                mul_a = p_reg;
                mul_b = P_COEF_LIN;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        acc_next  = acc_reg;
        b5_next   = b5_reg;
        b6_next   = b6_reg;
        sq_next   = sq_reg;
        b3_next   = b3_reg;
        b4_next   = b4_reg;
        p_next    = p_reg;
        res_next  = res_reg;
        dz_next   = dz_reg;
        qfix_next = qfix_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                res_next = '0;
                dz_next  = 1'b0;
            end
            S_T_X1:   acc_next = asr32(prod_reg, 5'd15);
            S_T_DEN:
            begin
                dz_next   = (den == '0);
                qfix_next = num_t[31] ^ den[31];
            end
            S_T_DIV:
            begin
                if (div_done)
                begin
                    b5_next  = b5_cand;
                    res_next = asr32(b5_cand + 32'd8, 5'd4);
                end
            end
            S_P_B6:   b6_next = b5_reg - B6_OFFSET;
            S_P_SQ:   sq_next = asr32(prod_reg, 5'd12);
            S_P_X2:   acc_next = asr32(prod_reg, 5'd11);
            S_P_X1:   acc_next = acc_reg + asr32(prod_reg, 5'd11);
            S_P_B3:
            begin
                b3_next  = asr32((({ac1_s[29:0], 2'b00} + acc_reg) << osr_reg) + 32'd2,
                                 5'd2);
                acc_next = asr32(prod_reg, 5'd13);
            end
            S_P_X3:   acc_next = asr32(acc_reg + asr32(prod_reg, 5'd16) + 32'd2, 5'd2);
            S_P_B4:   b4_next = prod_reg >> 15;
            S_P_B7:
            begin
                dz_next   = (b4_reg == '0);
                qfix_next = prod_reg[31];
            end
            S_P_DIV:
            begin
                if (div_done)
                begin
                    p_next = qfix_reg ? {div_quotient[30:0], 1'b0} : div_quotient;
                end
            end
            S_P_K2:   acc_next = asr32(prod_reg, 5'd16);
            S_P_SUM:
            begin
                res_next = p_reg + asr32(acc_reg + asr32(32'd0 - prod_reg, 5'd16)
                                         + P_COEF_OFS, 5'd4);
            end
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            b5_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            b5_reg    <= b5_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        acc_reg  <= acc_next;
        b6_reg   <= b6_next;
        sq_reg   <= sq_next;
        b3_reg   <= b3_next;
        b4_reg   <= b4_next;
        p_reg    <= p_next;
        res_reg  <= res_next;
        dz_reg   <= dz_next;
        qfix_reg <= qfix_next;
        if (in_acc)
        begin
            func_reg <= in_data.func;
            raw_reg  <= in_data.raw_value;
        end
        if (out_load)
        begin
            out_reg.kind        <= func_reg;
            out_reg.value       <= $signed(res_reg);
            out_reg.div_by_zero <= dz_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_T_DIV || state_reg == S_P_DIV))
        else $error("divider finished outside a wait state");

    // A zero divisor always yields a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.div_by_zero) |-> (out_data.value == '0))
        else $error("divide by zero result carries a nonzero value");

    // Only one item is in flight: acceptance closes the input until the result is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while an item is in progress");

    // A loaded result reports the kind of the item that produced it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid && out_data.kind == func_reg))
        else $error("result kind does not match the item");

endmodule

@@ design/bpc_div.sv @@
// Shared 32-bit unsigned restoring divider, one quotient bit per cycle.
module bpc_div
    import bpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    localparam int unsigned CNT_W = $clog2(DATA_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [DATA_W:0]   rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dsr_reg;

    logic [DATA_W:0]   rem_shift;
    logic [DATA_W+1:0] diff;
    logic              busy;

    assign busy      = (cnt_reg != '0);
    assign rem_shift = {rem_reg[DATA_W-1:0], quo_reg[DATA_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy && (cnt_reg == CNT_W'(1));
            if (start && !busy)
            begin
                cnt_reg <= CNT_W'(DATA_W);
            end
            else if (busy)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy)
        begin
            // Each step brings down one dividend bit and keeps the partial remainder.
            if (!diff[DATA_W+1])
            begin
                rem_reg <= diff[DATA_W:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the barometric pressure and temperature compensation unit.
module tb_top
    import bpc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic FUNC_TEMP = 1'b0;
    localparam logic FUNC_PRES = 1'b1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PLAN_LEN = 21;
    localparam int RAND_PHASES = 25;
    localparam int PHASE_ITEMS = 50;

    typedef enum int {
        SET_RESET,
        SET_DATASHEET,
        SET_MAX,
        SET_MIN,
        SET_TDIV0
    } cal_set_e;

    typedef struct {
        cal_set_e          set;
        logic              func;
        logic [RAW_W-1:0]  raw;
        bit                fixed;
        logic signed [31:0] value;
        logic              dz;
    } plan_row_t;

    typedef struct {
        bit   fixed;
        out_t result;
    } pinned_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    in_t                in_data;
    logic               out_valid;
    logic               out_ready;
    out_t               out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Shadow copy of the configuration and of the stored b5.
    logic [1:0]  cfg_osr = 2'd1;
    logic [15:0] cfg_ac1 = '0;
    logic [15:0] cfg_ac2 = '0;
    logic [15:0] cfg_ac3 = '0;
    logic [15:0] cfg_ac4 = '0;
    logic [31:0] cfg_ac5_ac6 = '0;
    logic [31:0] cfg_mc_md = '0;
    logic [31:0] cfg_b1_b2 = '0;
    logic [31:0] stored_b5 = '0;

    out_t    reading_q [$];
    pinned_t pin_q [$];
    int      fail_cnt = 0;
    int      cycle_cnt = 0;
    bit      no_gaps = 1'b0;

    out_t    exp_r;
    out_t    pred_r;
    pinned_t pin_e;

    baro_pressure_temp_compensation_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] sra32(input logic [31:0] v, input int unsigned n);
        return $unsigned($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Computes the compensated reading and updates the stored b5 like the block does.
    function automatic out_t compensate(input in_t it);
        logic [31:0] ut, ac5, ac6, mc, md, den, num;
        logic [31:0] ac1, ac2, ac3, ac4, b1, b2, up, b6, sq, t, b3, b4, b7, p;
        logic [31:0] x1, x2, x3;
        logic [1:0]  oss;
        longint      q;
        out_t        r;
        r.kind = it.func;
        r.value = '0;
        r.div_by_zero = 1'b0;
        if (it.func == FUNC_TEMP)
        begin
            ut = {16'd0, it.raw_value[15:0]};
            ac5 = {16'd0, cfg_ac5_ac6[31:16]};
            ac6 = {16'd0, cfg_ac5_ac6[15:0]};
            mc = sext16(cfg_mc_md[31:16]);
            md = sext16(cfg_mc_md[15:0]);
            x1 = sra32((ut - ac6) * ac5, 15);
            den = x1 + md;
            if (den == 32'd0)
            begin
                r.div_by_zero = 1'b1;
            end
            else
            begin
                num = mc << 11;
                // A 64-bit quotient wraps the most negative value over -1 correctly.
                q = longint'($signed(num)) / longint'($signed(den));
                x2 = q[31:0];
                stored_b5 = x1 + x2;
                r.value = sra32(stored_b5 + 32'd8, 4);
            end
        end
        else
        begin
            oss = cfg_osr;
            ac1 = sext16(cfg_ac1);
            ac2 = sext16(cfg_ac2);
            ac3 = sext16(cfg_ac3);
            ac4 = {16'd0, cfg_ac4};
            b1 = sext16(cfg_b1_b2[31:16]);
            b2 = sext16(cfg_b1_b2[15:0]);
            up = {8'd0, it.raw_value} >> (8 - int'(oss));
            b6 = stored_b5 - 32'd4000;
            sq = sra32(b6 * b6, 12);
            x1 = sra32(b2 * sq, 11);
            x2 = sra32(ac2 * b6, 11);
            x3 = x1 + x2;
            t = (ac1 * 32'd4 + x3) << oss;
            b3 = sra32(t + 32'd2, 2);
            x1 = sra32(ac3 * b6, 13);
            x2 = sra32(b1 * sq, 16);
            x3 = sra32(x1 + x2 + 32'd2, 2);
            b4 = (ac4 * (x3 + 32'd32768)) >> 15;
            b7 = (up - b3) * (32'd50000 >> oss);
            if (b4 == 32'd0)
            begin
                r.div_by_zero = 1'b1;
            end
            else
            begin
                if (b7 < 32'h8000_0000)
                    p = (b7 << 1) / b4;
                else
                    p = (b7 / b4) << 1;
                x1 = sra32(p, 8) * sra32(p, 8);
                x1 = sra32(x1 * 32'd3038, 16);
                x2 = sra32(32'd0 - 32'd7357 * p, 16);
                r.value = p + sra32(x1 + x2 + 32'd3791, 4);
            end
        end
        return r;
    endfunction

    // Results are checked before the item of the same edge is predicted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (reading_q.size() == 0)
                begin
                    $error("result item with no expected reading: kind %0d value %0d",
                           out_data.kind, out_data.value);
                    fail_cnt++;
                end
                else
                begin
                    exp_r = reading_q.pop_front();
                    if (out_data.kind !== exp_r.kind)
                    begin
                        $error("kind mismatch: expected %0d, actual %0d",
                               exp_r.kind, out_data.kind);
                        fail_cnt++;
                    end
                    if (out_data.value !== exp_r.value)
                    begin
                        $error("value mismatch: expected %0d, actual %0d",
                               exp_r.value, out_data.value);
                        fail_cnt++;
                    end
                    if (out_data.div_by_zero !== exp_r.div_by_zero)
                    begin
                        $error("div_by_zero mismatch: expected %0d, actual %0d",
                               exp_r.div_by_zero, out_data.div_by_zero);
                        fail_cnt++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                pred_r = compensate(in_data);
                if (pin_q.size() != 0)
                begin
                    pin_e = pin_q.pop_front();
                    if (pin_e.fixed)
                        pred_r = pin_e.result;
                end
                reading_q.push_back(pred_r);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            out_ready <= no_gaps || ($urandom_range(99) >= 29);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt >= CYCLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_OSR:     cfg_osr = data[1:0];
            REG_AC1:     cfg_ac1 = data[15:0];
            REG_AC2:     cfg_ac2 = data[15:0];
            REG_AC3:     cfg_ac3 = data[15:0];
            REG_AC4:     cfg_ac4 = data[15:0];
            REG_AC5_AC6: cfg_ac5_ac6 = data;
            REG_MC_MD:   cfg_mc_md = data;
            REG_B1_B2:   cfg_b1_b2 = data;
            default:     ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Upper bits of the narrow registers carry noise that the block must drop.
    task automatic load_calibration(input logic [1:0] osr, input logic [15:0] ac1,
                                    input logic [15:0] ac2, input logic [15:0] ac3,
                                    input logic [15:0] ac4, input logic [31:0] ac5_ac6,
                                    input logic [31:0] mc_md, input logic [31:0] b1_b2);
        apb_write(REG_OSR, {30'($urandom), osr});
        apb_write(REG_AC1, {16'($urandom), ac1});
        apb_write(REG_AC2, {16'($urandom), ac2});
        apb_write(REG_AC3, {16'($urandom), ac3});
        apb_write(REG_AC4, {16'($urandom), ac4});
        apb_write(REG_AC5_AC6, ac5_ac6);
        apb_write(REG_MC_MD, mc_md);
        apb_write(REG_B1_B2, b1_b2);
    endtask

    task automatic apply_set(input cal_set_e s);
        case (s)
            SET_DATASHEET: load_calibration(2'd0, 16'd408, -16'sd72, -16'sd14383, 16'd32741,
                                            {16'd32757, 16'd23153}, {-16'sd8711, 16'd2868},
                                            {16'd6190, 16'd4});
            SET_MAX:       load_calibration(2'd3, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF,
                                            32'hFFFF_FFFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF);
            SET_MIN:       load_calibration(2'd0, 16'h8000, 16'h8000, 16'h8000, 16'h0000,
                                            32'h0000_0000, 32'h8000_8000, 32'h8000_8000);
            SET_TDIV0:     load_calibration(2'd2, 16'd0, 16'd0, 16'd0, 16'd0,
                                            32'h0001_0000, 32'h8000_FFFF, 32'h0000_0000);
            default:       ;
        endcase
    endtask

    function automatic logic [15:0] jitter(input int base, input int span);
        return 16'(base + int'($urandom_range(2 * span)) - span);
    endfunction

    // Picks a calibration set: fully random, close to a real sensor, or one that
    // steers the divisors toward zero.
    task automatic random_calibration(output bit realistic);
        int          flavor;
        logic [15:0] ac4, ac5, md;
        flavor = $urandom_range(3);
        realistic = (flavor != 0);
        if (flavor == 0)
        begin
            load_calibration(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), $urandom, $urandom, $urandom);
        end
        else
        begin
            ac4 = jitter(32741, 800);
            ac5 = jitter(32757, 800);
            md = jitter(2868, 300);
            if (flavor == 3)
            begin
                ac4 = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(3));
                if ($urandom_range(1) == 0)
                begin
                    ac5 = 16'd0;
                    md = 16'd0;
                end
            end
            load_calibration(2'($urandom_range(3)), jitter(408, 300), jitter(-72, 100),
                             jitter(-14383, 900), ac4, {ac5, jitter(23153, 900)},
                             {jitter(-8711, 500), md}, {jitter(6190, 400), jitter(4, 8)});
        end
    endtask

    task automatic send_reading(input in_t it, input bit fixed, input out_t res);
        pinned_t pe;
        pe.fixed = fixed;
        pe.result = res;
        pin_q.push_back(pe);
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < 29)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (reading_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        plan_row_t plan [PLAN_LEN];
        cal_set_e  cur_set;
        in_t       it;
        out_t      res;
        bit        realistic;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;

        plan = '{
            // Reset calibration: both divisors are zero, so every reading is flagged.
            '{SET_RESET,     FUNC_PRES, 24'h000000, 1'b1, 0,       1'b1},
            '{SET_RESET,     FUNC_PRES, 24'hFFFFFF, 1'b1, 0,       1'b1},
            '{SET_RESET,     FUNC_TEMP, 24'h000000, 1'b1, 0,       1'b1},
            '{SET_RESET,     FUNC_TEMP, 24'hFFFFFF, 1'b1, 0,       1'b1},
            '{SET_DATASHEET, FUNC_TEMP, 24'd27898,  1'b1, 150,     1'b0},
            '{SET_DATASHEET, FUNC_PRES, 24'h5D2300, 1'b0, 0,       1'b0},
            '{SET_DATASHEET, FUNC_PRES, 24'h000000, 1'b0, 0,       1'b0},
            '{SET_DATASHEET, FUNC_PRES, 24'hFFFFFF, 1'b0, 0,       1'b0},
            '{SET_DATASHEET, FUNC_TEMP, 24'h000000, 1'b0, 0,       1'b0},
            '{SET_DATASHEET, FUNC_TEMP, 24'hFFFFFF, 1'b0, 0,       1'b0},
            '{SET_MAX,       FUNC_TEMP, 24'h000000, 1'b0, 0,       1'b0},
            '{SET_MAX,       FUNC_TEMP, 24'h00FFFF, 1'b0, 0,       1'b0},
            '{SET_MAX,       FUNC_PRES, 24'h000000, 1'b0, 0,       1'b0},
            '{SET_MAX,       FUNC_PRES, 24'hFFFFFF, 1'b0, 0,       1'b0},
            '{SET_MAX,       FUNC_PRES, 24'hA5A5A5, 1'b0, 0,       1'b0},
            '{SET_MIN,       FUNC_TEMP, 24'h000000, 1'b0, 0,       1'b0},
            '{SET_MIN,       FUNC_PRES, 24'hFFFFFF, 1'b1, 0,       1'b1},
            '{SET_MIN,       FUNC_TEMP, 24'hFF0000, 1'b0, 0,       1'b0},
            // Divisor of -1 on the temperature path, then a zero divisor that keeps b5.
            '{SET_TDIV0,     FUNC_TEMP, 24'h001234, 1'b1, 4194304, 1'b0},
            '{SET_TDIV0,     FUNC_TEMP, 24'h008000, 1'b1, 0,       1'b1},
            '{SET_TDIV0,     FUNC_PRES, 24'h5A5A5A, 1'b1, 0,       1'b1}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        cur_set = SET_RESET;
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].set != cur_set)
            begin
                settle();
                cur_set = plan[i].set;
                apply_set(cur_set);
            end
            it.func = plan[i].func;
            it.raw_value = plan[i].raw;
            res.kind = plan[i].func;
            res.value = plan[i].value;
            res.div_by_zero = plan[i].dz;
            send_reading(it, plan[i].fixed, res);
        end
        settle();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            no_gaps = (ph >= 8 && ph < 13);
            random_calibration(realistic);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                it.func = 1'($urandom_range(1));
                it.raw_value = RAW_W'($urandom);
                if (realistic && it.func == FUNC_TEMP && $urandom_range(99) < 70)
                    it.raw_value[15:0] = 16'($urandom_range(34000, 22000));
                send_reading(it, 1'b0, '0);
            end
            settle();
        end

        no_gaps = 1'b0;
        repeat (100) @(posedge clk);
        if (fail_cnt == 0 && reading_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
